>>> hw/rtl/vre_pkg.sv
// Shared types, constants and coefficient table for the vertex rotation engine.
package vre_pkg;

	// Command kinds carried on s_tuser
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_XFORM = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [1:0] CFG_HALF_EXTENT  = 2'd1;
	localparam logic [1:0] CFG_SCREEN_SIZE  = 2'd2;

	localparam logic [10:0] VERTEX_COUNT_RST = 11'd522;
	localparam logic [15:0] HALF_EXTENT_RST  = 16'd14000;
	localparam logic [11:0] SCREEN_SIZE_RST  = 12'd500;

	localparam int DEFAULT_MAX_VERTICES = 1024;

	// Port payload widths
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_DATA_W  = 16;
	localparam int COORD_W     = 32;
	localparam int VERTEX_W    = 3 * COORD_W;

	// Q1.15 matrix coefficients
	typedef logic signed [16:0] coef_t;
	localparam coef_t CO = 17'sd32752;
	localparam coef_t SI = 17'sd1029;
	localparam coef_t NS = -17'sd1029;
	localparam coef_t ON = 17'sd32768;
	localparam coef_t ZI = 17'sd36045;
	localparam coef_t ZO = 17'sd29789;
	localparam coef_t ZR = 17'sd0;

	// Indexed [op][row k][column j]; new[j] = sum_k old[k] * M[k][j]
	localparam coef_t MATS [8][3][3] = '{
		'{'{CO, NS, ZR}, '{SI, CO, ZR}, '{ZR, ZR, ON}},
		'{'{CO, SI, ZR}, '{NS, CO, ZR}, '{ZR, ZR, ON}},
		'{'{ON, ZR, ZR}, '{ZR, CO, SI}, '{ZR, NS, CO}},
		'{'{ON, ZR, ZR}, '{ZR, CO, NS}, '{ZR, SI, CO}},
		'{'{CO, ZR, NS}, '{ZR, ON, ZR}, '{SI, ZR, CO}},
		'{'{CO, ZR, SI}, '{ZR, ON, ZR}, '{NS, ZR, CO}},
		'{'{ZI, ZR, ZR}, '{ZR, ZI, ZR}, '{ZR, ZR, ZI}},
		'{'{ZO, ZR, ZR}, '{ZR, ZO, ZR}, '{ZR, ZR, ZO}}
	};

	// Rounding offset added before the >>> 15
	localparam int ACC_W = 51;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = 51'sd16384;

endpackage

>>> hw/rtl/vre_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module vre_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/vertex_rotation_engine.sv
// Vertex rotation engine top level: vertex table, 3x3 transform and screen projection.
//
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+------------------------------------------
// s_*      | in  | s_tvalid / s_tready   | tuser kind, tdata index/x/y/z/op
// m_*      | out | m_tvalid / m_tready   | tdata pixel_x, pixel_y
// cfg_*    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// Loads are accepted back to back. A read passes the RAM read, RPREP, RMUL, the
// 17-step shared-divisor restoring divider (RDIV) and ROUT into the output register.
// A transform walks min(vertex_count, MAX_VERTICES) entries: per vertex three multiply
// steps (one per source coordinate), one add and one write that also reads the next one.
// Reset clears the control registers and sets the config registers to their defaults;
// the table is not cleared. A result waiting on m_tready holds only a later read, in
// ROUT, and with it the command stream; loads and transforms keep flowing until then.
module vertex_rotation_engine #(
	parameter int MAX_VERTICES = vre_pkg::DEFAULT_MAX_VERTICES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Command stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] index, [41:10] coord_x, [73:42] coord_y, [105:74] coord_z,
	// [108:106] op, [111:109] zero
	input  logic [vre_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [1:0] kind
	input  logic [1:0]                      s_tuser,
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] pixel_x, [31:16] pixel_y
	output logic [vre_pkg::OUT_TDATA_W-1:0] m_tdata,
	// Configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [vre_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [16:0] MAX_EXT = 17'(MAX_VERTICES);
	localparam int CW_ = vre_pkg::COORD_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_XMUL  = 3'd1;
	localparam logic [2:0] ST_XACC  = 3'd2;
	localparam logic [2:0] ST_XWR   = 3'd3;
	localparam logic [2:0] ST_RPREP = 3'd4;
	localparam logic [2:0] ST_RMUL  = 3'd5;
	localparam logic [2:0] ST_RDIV  = 3'd6;
	localparam logic [2:0] ST_ROUT  = 3'd7;

	logic [2:0]  state_q;

	// Config registers
	logic [10:0] vcount_q;
	logic [15:0] hext_q;
	logic [11:0] ssize_q;
	logic [15:0] heff;

	// Input unpack
	logic        s_acc;
	logic [9:0]  in_index;
	logic [31:0] in_x, in_y, in_z;
	logic [2:0]  in_op;
	logic [16:0] idx_ext;
	logic        idx_ok;
	logic [16:0] vc_ext;
	logic [CW-1:0] n_now;

	// RAM ports
	logic                      ram_we, ram_re;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [vre_pkg::VERTEX_W-1:0] ram_wdata, ram_rdata;

	// Transform datapath
	logic [2:0]    op_q;
	logic [1:0]    k_q;
	logic [CW-1:0] i_q, n_q, i_next;
	logic signed [CW_-1:0] coord_k;
	logic signed [48:0] prod_s1 [3];
	logic signed [vre_pkg::ACC_W-1:0] acc_q [3];
	logic signed [vre_pkg::ACC_W-1:0] acc_fin [3];
	logic [CW_-1:0] new_c [3];

	// Projection datapath, lane 0 is x, lane 1 is y
	logic signed [33:0] hfull;
	logic signed [33:0] a_l [2];
	logic [32:0]   mag_q [2];
	logic          neg_q [2];
	logic [27:0]   rem_q [2];
	logic [31:0]   dv_q;
	logic [16:0]   quo_q [2];
	logic          ovf_q [2];
	logic [4:0]    cnt_q;
	logic [15:0]   pix [2];
	logic          out_free;
	logic [vre_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic          m_tvalid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;

	assign in_index = s_tdata[9:0];
	assign in_x     = s_tdata[41:10];
	assign in_y     = s_tdata[73:42];
	assign in_z     = s_tdata[105:74];
	assign in_op    = s_tdata[108:106];
	assign idx_ext  = {7'd0, in_index};
	assign idx_ok   = idx_ext < MAX_EXT;

	// Transform walks min(vertex_count, MAX_VERTICES) entries
	assign vc_ext = {6'd0, vcount_q};
	assign n_now  = (vc_ext > MAX_EXT) ? CW'(MAX_VERTICES) : vc_ext[CW-1:0];
	assign i_next = i_q + CW'(1);

	assign heff = (hext_q == 16'd0) ? 16'd1 : hext_q;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= vre_pkg::VERTEX_COUNT_RST;
			hext_q   <= vre_pkg::HALF_EXTENT_RST;
			ssize_q  <= vre_pkg::SCREEN_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vre_pkg::CFG_VERTEX_COUNT: vcount_q <= cfg_data[10:0];
				vre_pkg::CFG_HALF_EXTENT:  hext_q   <= cfg_data;
				vre_pkg::CFG_SCREEN_SIZE:  ssize_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	vre_ram #(
		.WIDTH(vre_pkg::VERTEX_W),
		.DEPTH(MAX_VERTICES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// acc_fin adds the last product in the add cycle; the write cycle takes
	// floor(acc / 2^15) of the finished sum, saturated to 32 bits
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic signed [vre_pkg::ACC_W-1:0] sh;
			acc_fin[j] = acc_q[j] + vre_pkg::ACC_W'(prod_s1[j]);
			sh = acc_q[j] >>> 15;
			if (sh > $signed(vre_pkg::ACC_W'(32'h7FFF_FFFF))) begin
				new_c[j] = 32'h7FFF_FFFF;
			end else if (sh < -$signed(vre_pkg::ACC_W'(33'h0_8000_0000))) begin
				new_c[j] = 32'h8000_0000;
			end else begin
				new_c[j] = sh[31:0];
			end
		end
	end

	// RAM port control: loads write at accept, the walk writes vertex i while reading i+1
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_ext[AW-1:0];
		ram_wdata = {in_z, in_y, in_x};
		ram_re    = 1'b0;
		ram_raddr = idx_ext[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					priority if (s_tuser == vre_pkg::KIND_LOAD) begin
						ram_we = idx_ok;
					end else if (s_tuser == vre_pkg::KIND_XFORM) begin
						ram_re    = (n_now != '0);
						ram_raddr = '0;
					end else if (s_tuser == vre_pkg::KIND_READ) begin
						ram_re = idx_ok;
					end
				end
			end
			ST_XWR: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[AW-1:0];
				ram_wdata = {new_c[2], new_c[1], new_c[0]};
				ram_re    = (i_next != n_q);
				ram_raddr = i_next[AW-1:0];
			end
			default: ;
		endcase
	end

	// Source coordinate k of the vertex held in the RAM read register
	always_comb begin
		unique case (k_q)
			2'd0:    coord_k = $signed(ram_rdata[31:0]);
			2'd1:    coord_k = $signed(ram_rdata[63:32]);
			default: coord_k = $signed(ram_rdata[95:64]);
		endcase
	end

	// Projection prep: x + H*2^16 and H*2^16 - y
	assign hfull  = $signed({2'b00, heff, 16'd0});
	assign a_l[0] = $signed({{2{ram_rdata[31]}}, ram_rdata[31:0]}) + hfull;
	assign a_l[1] = hfull - $signed({{2{ram_rdata[63]}}, ram_rdata[63:32]});

	// Truncate toward zero and saturate to 16 bits
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic [16:0] qn;
			qn = ~quo_q[l] + 17'd1;
			if (neg_q[l]) begin
				pix[l] = (ovf_q[l] || quo_q[l] > 17'd32768) ? 16'h8000 : qn[15:0];
			end else begin
				pix[l] = (ovf_q[l] || quo_q[l] > 17'd32767) ? 16'h7FFF : quo_q[l][15:0];
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
			op_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == vre_pkg::KIND_XFORM && n_now != '0) begin
							state_q <= ST_XMUL;
							op_q    <= in_op;
							n_q     <= n_now;
							i_q     <= '0;
							k_q     <= '0;
						end else if (s_tuser == vre_pkg::KIND_READ && idx_ok) begin
							state_q <= ST_RPREP;
						end
					end
				end
				ST_XMUL: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) begin
						state_q <= ST_XACC;
					end
				end
				ST_XACC: state_q <= ST_XWR;
				ST_XWR: begin
					k_q <= '0;
					i_q <= i_next;
					state_q <= (i_next == n_q) ? ST_IDLE : ST_XMUL;
				end
				ST_RPREP: state_q <= ST_RMUL;
				ST_RMUL: begin
					cnt_q   <= '0;
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= ST_ROUT;
					end
				end
				ST_ROUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Multiply-accumulate over the three source coordinates
	always_ff @(posedge clk) begin
		if (state_q == ST_XMUL) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[j] <= coord_k * vre_pkg::MATS[op_q][k_q][j];
				if (k_q == 2'd0) begin
					acc_q[j] <= vre_pkg::ROUND_HALF;
				end else begin
					acc_q[j] <= acc_q[j] + vre_pkg::ACC_W'(prod_s1[j]);
				end
			end
		end else if (state_q == ST_XACC) begin
			for (int j = 0; j < 3; j++) begin
				acc_q[j] <= acc_fin[j];
			end
		end
	end

	// Projection: |A| * S >> 17, then 17 quotient bits against H (restoring)
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RPREP: begin
				for (int l = 0; l < 2; l++) begin
					logic [33:0] m;
					m = a_l[l][33] ? (~a_l[l] + 34'd1) : a_l[l];
					neg_q[l] <= a_l[l][33];
					mag_q[l] <= m[32:0];
				end
			end
			ST_RMUL: begin
				for (int l = 0; l < 2; l++) begin
					logic [44:0] pm;
					pm = 45'(mag_q[l]) * 45'(ssize_q);
					rem_q[l] <= pm[44:17];
				end
				dv_q <= {heff, 16'd0};
			end
			ST_RDIV: begin
				for (int l = 0; l < 2; l++) begin
					logic take;
					take = {4'd0, rem_q[l]} >= dv_q;
					if (cnt_q == 5'd0) begin
						ovf_q[l] <= {5'd0, rem_q[l]} >= {heff, 17'd0};
					end
					if (take) begin
						rem_q[l] <= rem_q[l] - dv_q[27:0];
					end
					quo_q[l] <= {quo_q[l][15:0], take};
				end
				dv_q <= dv_q >> 1;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_ROUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUT && out_free) begin
			m_tdata_q <= {pix[1], pix[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/vre_checker.sv
// Port-level assertions for the vertex rotation engine, bound to the top level.
module vre_checker #(
	parameter int MAX_VERTICES = vre_pkg::DEFAULT_MAX_VERTICES
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [vre_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic [1:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [vre_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam logic [16:0] MAX_EXT = 17'(MAX_VERTICES);

	logic rd_go;
	assign rd_go = s_tvalid && s_tready && (s_tuser == vre_pkg::KIND_READ)
		&& ({7'd0, s_tdata[9:0]} < MAX_EXT);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A read occupies the engine
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go |=> !s_tready)
		else $error("command taken during read");

	// Loads never stall the command stream
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == vre_pkg::KIND_LOAD) |=> s_tready)
		else $error("load stalled the engine");

	// A read result cannot appear right after the command
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
		else $error("read result too early");

endmodule

bind vertex_rotation_engine vre_checker #(.MAX_VERTICES(MAX_VERTICES)) u_vre_checker (.*);

>>> tb/sv/vertex_rotation_engine_test.sv
// Self-checking stream testbench for the vertex rotation engine: loads, transforms, projected reads.
`timescale 1ns / 100ps

module vertex_rotation_engine_test;

	// Table depth of the instance under test (default parameter)
	localparam int TABLE_DEPTH = vre_pkg::DEFAULT_MAX_VERTICES;

	// Unused command kind, carries no work and no result
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Transform selectors
	localparam logic [2:0] OP_CW       = 3'd0;
	localparam logic [2:0] OP_CCW      = 3'd1;
	localparam logic [2:0] OP_UP       = 3'd2;
	localparam logic [2:0] OP_DOWN     = 3'd3;
	localparam logic [2:0] OP_LEFT     = 3'd4;
	localparam logic [2:0] OP_RIGHT    = 3'd5;
	localparam logic [2:0] OP_ZOOM_IN  = 3'd6;
	localparam logic [2:0] OP_ZOOM_OUT = 3'd7;

	// Q1.15 coefficients: cos and sin of pi/100, unity, 1.1 and 1/1.1
	localparam longint COS_Q15      = 32752;
	localparam longint SIN_Q15      = 1029;
	localparam longint ONE_Q15      = 32768;
	localparam longint ZOOM_IN_Q15  = 36045;
	localparam longint ZOOM_OUT_Q15 = 29789;

	// Random traffic stops here before the full-table phase
	localparam int MAIN_ITEMS  = 250;
	// Watchdog, several times the slowest legal run
	localparam int CYCLE_LIMIT = 1500000;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [vre_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [1:0]                      s_tuser   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [vre_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [1:0]                      cfg_index = '0;
	logic [vre_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	always #5 clk = ~clk;

	vertex_rotation_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [9:0] index, [41:10] x, [73:42] y, [105:74] z, [108:106] op
		.s_tuser   (s_tuser),   // [1:0] kind
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [15:0] pixel_x, [31:16] pixel_y
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Expected projection of one read, oldest first in the queue
	typedef struct packed {
		logic [9:0]         vertex;
		logic signed [15:0] py;
		logic signed [15:0] px;
	} pixel_t;

	// Shadow of the vertex table and of the view registers
	logic signed [31:0] vert_x [TABLE_DEPTH];
	logic signed [31:0] vert_y [TABLE_DEPTH];
	logic signed [31:0] vert_z [TABLE_DEPTH];
	bit                 loaded [TABLE_DEPTH];
	logic [10:0]        cur_vertex_count = 11'd522;
	logic [15:0]        cur_half_extent  = 16'd14000;
	logic [11:0]        cur_screen_size  = 12'd500;

	pixel_t pixel_queue [$];
	int     mismatch_count  = 0;
	int     items_sent      = 0;
	int     burst_left      = 0;
	int     fill_mark       = 0;
	bit     xform_in_flight = 1'b0;
	int     cycle_count     = 0;
	int     stall_tick      = 0;
	int     stall_mode      = 0;

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Entries a transform walks
	function automatic int walk_length();
		int n;
		n = cur_vertex_count;
		return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
	endfunction

	// Coefficient [k][j]: new[j] = sum over k of old[k] * M[k][j].
	// A rotation has cos on its plane's diagonal, t at [p][q] and -t at [q][p].
	function automatic longint xform_coef(input logic [2:0] op, input int k, input int j);
		int     p;
		int     q;
		longint t;
		case (op)
			OP_CW: begin
				p = 0; q = 1; t = -SIN_Q15;
			end
			OP_CCW: begin
				p = 0; q = 1; t = SIN_Q15;
			end
			OP_UP: begin
				p = 1; q = 2; t = SIN_Q15;
			end
			OP_DOWN: begin
				p = 1; q = 2; t = -SIN_Q15;
			end
			OP_LEFT: begin
				p = 0; q = 2; t = -SIN_Q15;
			end
			OP_RIGHT: begin
				p = 0; q = 2; t = SIN_Q15;
			end
			default: begin
				if (k != j) return 0;
				return (op == OP_ZOOM_IN) ? ZOOM_IN_Q15 : ZOOM_OUT_Q15;
			end
		endcase
		if (k == j) return (k == p || k == q) ? COS_Q15 : ONE_Q15;
		if (k == p && j == q) return t;
		if (k == q && j == p) return -t;
		return 0;
	endfunction

	// Every row uses the vertex's original coordinates; round half up, saturate
	function automatic void rotate_table(input logic [2:0] op);
		longint             src [3];
		longint             acc;
		logic signed [31:0] res [3];
		int                 n;
		n = walk_length();
		for (int i = 0; i < n; i++) begin
			src[0] = vert_x[i];
			src[1] = vert_y[i];
			src[2] = vert_z[i];
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += src[k] * xform_coef(op, k, j);
				res[j] = clamp32((acc + 64'sd16384) >>> 15);
			end
			vert_x[i] = res[0];
			vert_y[i] = res[1];
			vert_z[i] = res[2];
		end
	endfunction

	// World [-H, +H] onto [0, S], y flipped, truncated toward zero; H of zero acts as one
	function automatic pixel_t project_vertex(input logic [9:0] idx);
		longint h;
		longint s;
		longint den;
		longint nx;
		longint ny;
		pixel_t p;
		h = cur_half_extent;
		if (h == 0) h = 1;
		s = cur_screen_size;
		den = 2 * h * 65536;
		nx = (vert_x[idx] + h * 65536) * s;
		ny = s * den - (vert_y[idx] + h * 65536) * s;
		p.vertex = idx;
		p.px = clamp16(nx / den);
		p.py = clamp16(ny / den);
		return p;
	endfunction

	// Entries below the returned index are all loaded
	function automatic int first_unloaded();
		while (fill_mark < TABLE_DEPTH && loaded[fill_mark]) fill_mark++;
		return fill_mark;
	endfunction

	// Mostly fill the table from the bottom, sometimes overwrite anywhere
	function automatic logic [9:0] pick_load_index();
		if (first_unloaded() < TABLE_DEPTH && $urandom_range(0, 99) < 85) return 10'(fill_mark);
		return 10'($urandom);
	endfunction

	// Reads only touch entries that hold a loaded vertex
	function automatic logic [9:0] pick_read_index();
		logic [9:0] idx;
		repeat (32) begin
			idx = 10'($urandom);
			if (loaded[idx]) return idx;
		end
		return 10'($urandom_range(0, first_unloaded() - 1));
	endfunction

	// Mix of in-view coordinates, small values, near-limit values and raw noise
	function automatic logic signed [31:0] rand_coord();
		longint span;
		longint v;
		span = cur_half_extent;
		if (span == 0) span = 1;
		span = span * 65536;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				v = longint'({$urandom, $urandom} % 64'(2 * span + 1)) - span;
				return clamp32(v);
			end
			2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: begin
				if ($urandom_range(0, 1)) return 32'sh7fffffff - 32'($urandom_range(0, 255));
				return 32'sh80000000 + 32'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// One command transaction; the shadow model advances at the accepting edge
	task automatic send_command(input logic [1:0] kind, input logic [9:0] idx,
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z, input logic [2:0] op);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, op, z, y, x, idx};
		do @(posedge clk); while (!s_tready);
		case (kind)
			vre_pkg::KIND_LOAD: begin
				vert_x[idx] = x;
				vert_y[idx] = y;
				vert_z[idx] = z;
				loaded[idx] = 1'b1;
			end
			vre_pkg::KIND_XFORM: begin
				rotate_table(op);
				xform_in_flight = 1'b1;
			end
			vre_pkg::KIND_READ: pixel_queue.push_back(project_vertex(idx));
			default: ;
		endcase
		items_sent++;
	endtask

	// Quiet the command side, drain all reads, then let any transform finish its walk
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (xform_in_flight ? 5 * walk_length() + 40 : 40) @(posedge clk);
		xform_in_flight = 1'b0;
	endtask

	task automatic cfg_write(input logic [1:0] reg_idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (reg_idx)
			vre_pkg::CFG_VERTEX_COUNT: cur_vertex_count = value[10:0];
			vre_pkg::CFG_HALF_EXTENT:  cur_half_extent  = value;
			default:                   cur_screen_size  = value[11:0];
		endcase
	endtask

	// New view setting, written only once the engine is idle
	task automatic set_view(input logic [15:0] count_word, input logic [15:0] half_word,
		input logic [15:0] screen_word);
		settle();
		cfg_write(vre_pkg::CFG_VERTEX_COUNT, count_word);
		cfg_write(vre_pkg::CFG_HALF_EXTENT, half_word);
		cfg_write(vre_pkg::CFG_SCREEN_SIZE, screen_word);
		cfg_valid <= 1'b0;
	endtask

	// A transform must never walk an entry that was never loaded
	task automatic cover_walk();
		int n;
		n = walk_length();
		for (int i = 0; i < n; i++) begin
			if (!loaded[i])
				send_command(vre_pkg::KIND_LOAD, 10'(i), rand_coord(), rand_coord(),
					rand_coord(), OP_CW);
		end
	endtask

	task automatic run_session(input int len);
		int roll;
		repeat (len) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				send_command(vre_pkg::KIND_LOAD, pick_load_index(), rand_coord(),
					rand_coord(), rand_coord(), 3'($urandom));
			end else if (roll < 85) begin
				send_command(vre_pkg::KIND_READ, pick_read_index(), $urandom, $urandom,
					$urandom, 3'($urandom));
			end else if (roll < 93) begin
				cover_walk();
				send_command(vre_pkg::KIND_XFORM, 10'($urandom), $urandom, $urandom,
					$urandom, 3'($urandom));
			end else begin
				send_command(KIND_UNUSED, 10'($urandom), $urandom, $urandom, $urandom,
					3'($urandom));
			end
		end
	endtask

	// Reset view: 522 entries, half range 14000, 500 pixels. No transform here,
	// the walk would reach entries that were never loaded.
	task automatic test_reset_defaults();
		send_command(vre_pkg::KIND_LOAD, 10'd0, 32'sd0, 32'sd0, 32'sd0, OP_CW);
		send_command(vre_pkg::KIND_READ, 10'd0, 32'sd0, 32'sd0, 32'sd0, OP_CW);
		send_command(vre_pkg::KIND_LOAD, 10'd1, 32'sd917504000, -32'sd917504000, 32'sd0,
			OP_CW);
		send_command(vre_pkg::KIND_READ, 10'd1, 32'sd0, 32'sd0, 32'sd0, OP_CW);
	endtask

	// Coordinate extremes, top table entry, unused kind and every transform
	task automatic test_directed();
		set_view(16'd4, 16'd14000, 16'd500);
		send_command(vre_pkg::KIND_LOAD, 10'd2, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			OP_CW);
		send_command(vre_pkg::KIND_LOAD, 10'd3, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			OP_CW);
		send_command(vre_pkg::KIND_LOAD, 10'd1023, 32'sd6553600, -32'sd196608000,
			32'sh12345678, OP_ZOOM_OUT);
		send_command(vre_pkg::KIND_READ, 10'd1023, 32'sd0, 32'sd0, 32'sd0, OP_CW);
		// unused kind with live-looking payload must leave entry 0 alone
		send_command(KIND_UNUSED, 10'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			OP_ZOOM_IN);
		send_command(vre_pkg::KIND_READ, 10'd0, 32'sd0, 32'sd0, 32'sd0, OP_CW);
		for (int o = 0; o < 8; o++) begin
			send_command(vre_pkg::KIND_XFORM, 10'd0, 32'sd0, 32'sd0, 32'sd0, 3'(o));
			send_command(vre_pkg::KIND_READ, 10'(o % 4), 32'sd0, 32'sd0, 32'sd0, OP_CW);
		end
	endtask

	// Sessions of random traffic, each under a fresh view setting. The first three pin
	// register extremes: zero count/half range/screen, then max half range/screen, then both at one.
	task automatic test_random_traffic();
		int          session;
		int          top;
		int          count;
		int          roll;
		logic [4:0]  junk;
		logic [15:0] count_word;
		logic [15:0] half_word;
		logic [15:0] screen_word;
		session = 0;
		while (items_sent < MAIN_ITEMS || session < 3) begin
			// keep the walk within about eight entries of the loaded prefix
			top = first_unloaded() + 8;
			if (top > TABLE_DEPTH) top = TABLE_DEPTH;
			roll = $urandom_range(0, 9);
			if (roll == 0) count = 0;
			else if (roll < 8) count = $urandom_range(1, (top < 48) ? top : 48);
			else count = $urandom_range(1, top);
			// bits above the register width are dropped by the engine
			junk = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd0;
			count_word = {junk, 11'(count)};
			roll = $urandom_range(0, 19);
			if (roll < 3) half_word = 16'd0;
			else if (roll < 6) half_word = 16'd1;
			else if (roll < 9) half_word = 16'd65535;
			else if (roll < 11) half_word = 16'd14000;
			else half_word = 16'($urandom_range(1, 65535));
			roll = $urandom_range(0, 19);
			if (roll < 2) screen_word = 16'd0;
			else if (roll < 4) screen_word = 16'd1;
			else if (roll < 7) screen_word = 16'd4095;
			else if (roll < 9) screen_word = 16'd500;
			else screen_word = 16'($urandom_range(1, 4095));
			if ($urandom_range(0, 3) == 0) screen_word[15:12] = 4'($urandom);
			case (session)
				0: begin
					count_word = 16'd0; half_word = 16'd0; screen_word = 16'd0;
				end
				1: begin
					count_word = {5'h1f, 11'd4}; half_word = 16'd65535; screen_word = 16'd4095;
				end
				2: begin
					half_word = 16'd1; screen_word = 16'hf001;
				end
				default: ;
			endcase
			set_view(count_word, half_word, screen_word);
			run_session($urandom_range(40, 120));
			session++;
		end
	endtask

	// Whole table walked: count at the table size, at the field maximum and between
	task automatic test_full_table();
		logic [15:0] count_word;
		for (int pass = 0; pass < 3; pass++) begin
			if (pass == 0) count_word = 16'd1024;
			else if (pass == 1) count_word = 16'd2047;
			else count_word = {5'($urandom), 11'($urandom_range(1025, 2047))};
			set_view(count_word, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4095)));
			cover_walk();
			send_command(vre_pkg::KIND_XFORM, 10'($urandom), $urandom, $urandom, $urandom,
				3'($urandom));
			run_session(20);
		end
	endtask

	// Result checker and receiver stall pattern. The stall mode is redrawn at random whenever
	// stall_tick hits a multiple of its period: always ready, coin flip, one cycle in four, or long stalls.
	always @(posedge clk) begin : result_check
		pixel_t             want;
		logic signed [15:0] got_x;
		logic signed [15:0] got_y;
		if (m_tvalid && m_tready) begin
			got_x = m_tdata[15:0];
			got_y = m_tdata[31:16];
			if (pixel_queue.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: pixel_x %0d pixel_y %0d", got_x, got_y);
				mismatch_count++;
			end else begin
				want = pixel_queue.pop_front();
				if (got_x !== want.px || got_y !== want.py) begin
					if (mismatch_count < 10)
						$display("vertex %0d: pixel_x exp %0d got %0d, pixel_y exp %0d got %0d",
							want.vertex, want.px, got_x, want.py, got_y);
					mismatch_count++;
				end
			end
		end
		stall_tick++;
		if (stall_tick % 512 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (stall_tick % 4 == 0);
			default: m_tready <= (stall_tick % 32 >= 27);
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vertex_rotation_engine: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random_traffic();
		test_full_table();
		settle();
		if (mismatch_count == 0) begin
			$display("vertex_rotation_engine: match");
		end else begin
			$display("vertex_rotation_engine: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/vre_pkg.sv
hw/rtl/vre_ram.sv
hw/rtl/vertex_rotation_engine.sv
hw/rtl/vre_checker.sv
tb/sv/vertex_rotation_engine_test.sv
